// ===== src/b58_pkg.sv =====
// shared constants, types and the character table of the base58 encoder
package b58_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned DIGIT_W     = 6;
	localparam int unsigned DIGITS_MAX  = 6;
	localparam int unsigned CNT_W       = $clog2(DIGITS_MAX + 1);
	localparam int unsigned IDX_W       = $clog2(DIGITS_MAX);
	localparam int unsigned RADIX       = 58;

	// v / 58 == (v >> 1) / 29 == ((v >> 1) * RECIP) >> RECIP_SHIFT for all 32-bit v
	localparam int unsigned RECIP_W     = 32;
	localparam logic [RECIP_W-1:0] RECIP = 32'd2369637129;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned PROD_W      = VALUE_W - 1 + RECIP_W;
	localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_EMIT
	} b58_state_t;

	typedef struct packed {
		logic [QUO_W-1:0]   quo;
		logic [DIGIT_W-1:0] rem;
	} b58_div_res_t;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic [DIGIT_W-1:0] digit;
	} b58_stk_ctl_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] top;
		logic               single;
	} b58_stk_stat_t;

	// digits without 0, lowercase without l, uppercase without I and O
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < 6'd9)
			c = 7'h31 + dx;
		else if (d < 6'd20)
			c = 7'h61 + (dx - 7'd9);
		else if (d < 6'd34)
			c = 7'h6d + (dx - 7'd20);
		else if (d < 6'd42)
			c = 7'h41 + (dx - 7'd34);
		else if (d < 6'd47)
			c = 7'h4a + (dx - 7'd42);
		else if (d < 6'd58)
			c = 7'h50 + (dx - 7'd47);
		else
			c = 7'h31;
		return c;
	endfunction

endpackage

// ===== src/b58_in_if.sv =====
// input channel: one identifier per item
interface b58_in_if;
	logic                          valid;
	logic                          ready;
	logic [b58_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== src/b58_out_if.sv =====
// output channel: one base58 character per item
interface b58_out_if;
	logic                          valid;
	logic                          ready;
	logic [b58_pkg::CHAR_W-1:0]    char_code;
	logic                          last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== src/b58_div58.sv =====
// shared divide-by-58 unit: reciprocal multiply, then remainder on the next cycle
module b58_div58 (
	input  logic                          clk,
	input  logic                          ld,
	input  logic [b58_pkg::VALUE_W-1:0]   dividend,
	output b58_pkg::b58_div_res_t         res
);
	import b58_pkg::*;

	logic [PROD_W-1:0]    prod;
	logic [QUO_W-1:0]     quo_s1;
	logic [DIGIT_W-1:0]   dvd_lo_s1;
	logic [2*DIGIT_W-1:0] q58;

	assign prod = PROD_W'(dividend[VALUE_W-1:1]) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ld) begin
			quo_s1    <= prod[PROD_W-1 -: QUO_W];
			dvd_lo_s1 <= dividend[DIGIT_W-1:0];
		end
	end

	// remainder lies in 0..57, so the low bits of v - 58q suffice
	assign q58     = (2*DIGIT_W)'(quo_s1[DIGIT_W-1:0]) * (2*DIGIT_W)'(RADIX);
	assign res.quo = quo_s1;
	assign res.rem = dvd_lo_s1 - q58[DIGIT_W-1:0];

endmodule

// ===== src/b58_digit_stack.sv =====
// digit stack: remainders pushed least significant first, popped most significant first
module b58_digit_stack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b58_pkg::b58_stk_ctl_t   ctl,
	output b58_pkg::b58_stk_stat_t  stat
);
	import b58_pkg::*;

	logic [DIGIT_W-1:0] mem_q [DIGITS_MAX];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   top_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[cnt_q[IDX_W-1:0]] <= ctl.digit;
		end
	end

	assign top_idx     = (cnt_q == '0) ? '0 : cnt_q - CNT_W'(1);
	assign stat.top    = mem_q[top_idx[IDX_W-1:0]];
	assign stat.single = (cnt_q == CNT_W'(1));

endmodule

// ===== src/base58_uid_encoder.sv =====
// top level: base58 encoder of 32-bit identifiers
// Each accepted identifier is turned into one to six ASCII base58 characters, most
// significant first, the final one flagged by last; zero gives the single character '1'.
// One identifier is in work at a time and req.ready is low until its last character is
// taken. A single divide-by-58 unit (a 31x32 reciprocal multiply, then a remainder step)
// yields one digit per pass through the multiply and subtract states, and the digits then
// leave one per cycle from a small stack while the receiver is ready.
module base58_uid_encoder (
	input  logic        clk,
	input  logic        arst_n,
	b58_in_if.sink      req,
	b58_out_if.source   rsp
);
	import b58_pkg::*;

	b58_state_t     state_q;
	b58_state_t     state_d;
	logic [VALUE_W-1:0] cur_q;
	logic           accept;
	logic           div_ld;
	b58_div_res_t   div_res;
	b58_stk_ctl_t   stk_ctl;
	b58_stk_stat_t  stk_stat;

	assign accept = req.valid && req.ready;

	b58_div58 u_div (
		.clk      (clk),
		.ld       (div_ld),
		.dividend (cur_q),
		.res      (div_res)
	);

	b58_digit_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.stat   (stk_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= req.value;
		end else if (state_q == ST_SUB) begin
			cur_q <= VALUE_W'(div_res.quo);
		end
	end

	always_comb begin
		state_d       = state_q;
		req.ready     = 1'b0;
		rsp.valid     = 1'b0;
		div_ld        = 1'b0;
		stk_ctl.push  = 1'b0;
		stk_ctl.pop   = 1'b0;
		stk_ctl.digit = div_res.rem;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				div_ld  = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				stk_ctl.push = 1'b1;
				// a zero quotient means this remainder was the leading digit
				state_d = (div_res.quo == '0) ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					stk_ctl.pop = 1'b1;
					if (stk_stat.single) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp.char_code = digit_char(stk_stat.top);
	assign rsp.last      = stk_stat.single;

endmodule

// ===== src/b58_checker.sv =====
// port-level checks of the base58 encoder and their binding to the top level
module b58_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [b58_pkg::CHAR_W-1:0]    rsp_char_code,
	input logic                          rsp_last
);
	import b58_pkg::*;

	// one identifier at a time: never ready while characters are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("input ready while a character is offered");

	// an accepted item needs a divide step before any character appears
	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (!rsp_valid && !req_ready))
		else $error("character or ready right after an accepted item");

	// after the flagged character the block drops valid and reopens its input
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && rsp_last) |=> (!rsp_valid && req_ready))
		else $error("output continues after the last character");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_char_code) && $stable(rsp_last)))
		else $error("stalled character changed");

endmodule

bind base58_uid_encoder b58_checker u_b58_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_char_code (rsp.char_code),
	.rsp_last      (rsp.last)
);

// ===== bench/b58_uid_checker.sv =====
// checker: predicts the base58 characters of each accepted identifier and compares them
module b58_uid_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [b58_pkg::VALUE_W-1:0] in_value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [b58_pkg::CHAR_W-1:0]  out_char,
	input  logic                        out_last,
	output int                          fail_count,
	output int                          chars_pending
);
	import b58_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} b58_char_t;

	// character i of the alphabet sits at bits [8*(57-i) +: 8]
	localparam logic [8*58-1:0] ALPHABET =
		"123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

	b58_char_t expected_chars[$];

	assign chars_pending = expected_chars.size();

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [7:0] b;
		b = ALPHABET[8*(57 - int'(d)) +: 8];
		return b[CHAR_W-1:0];
	endfunction

	// split into base58 digits, least significant first, then queue most significant first
	function automatic void queue_encoding(input logic [VALUE_W-1:0] v);
		logic [DIGIT_W-1:0] digs[DIGITS_MAX];
		logic [VALUE_W-1:0] rest;
		int                 n;
		b58_char_t          c;
		rest = v;
		n = 0;
		do begin
			digs[n] = DIGIT_W'(rest % 32'd58);
			rest = rest / 32'd58;
			n++;
		end while (rest != 0);
		for (int k = n - 1; k >= 0; k--) begin
			c.char_code = glyph(digs[k]);
			c.last = (k == 0);
			expected_chars.push_back(c);
		end
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		b58_char_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				queue_encoding(in_value);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected item char_code=%h last=%b", $time,
						out_char, out_last);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.char_code) begin
						$display("%0t: char_code expected %h actual %h", $time,
							want.char_code, out_char);
						fail_count++;
					end
					if (out_last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time,
							want.last, out_last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== bench/tb.sv =====
// testbench top: drives identifiers into the base58 encoder and gives the verdict
module tb;
	import b58_pkg::*;

	localparam int RANDOM_PER_PHASE = 115;
	localparam int LIMIT_CYCLES     = 400000;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   fail_count;
	int   chars_pending;
	int   cycles;

	b58_in_if  req_ch ();
	b58_out_if rsp_ch ();

	base58_uid_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	b58_uid_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (req_ch.valid),
		.in_ready      (req_ch.ready),
		.in_value      (req_ch.value),
		.out_valid     (rsp_ch.valid),
		.out_ready     (rsp_ch.ready),
		.out_char      (rsp_ch.char_code),
		.out_last      (rsp_ch.last),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("base58_uid_encoder verification failed");
			$finish;
		end
	end

	// receiver side
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.value <= $urandom;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// spread values over all digit counts, plus some plain random words
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] lo[DIGITS_MAX];
		logic [VALUE_W-1:0] hi[DIGITS_MAX];
		int                 k;
		lo = '{32'd0, 32'd58, 32'd3364, 32'd195112, 32'd11316496, 32'd656356768};
		hi = '{32'd57, 32'd3363, 32'd195111, 32'd11316495, 32'd656356767, 32'hFFFFFFFF};
		if ($urandom_range(9) < 3)
			return $urandom;
		k = $urandom_range(DIGITS_MAX - 1);
		return $urandom_range(hi[k], lo[k]);
	endfunction

	initial begin
		logic [VALUE_W-1:0] directed[$];
		cycles = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// digit count boundaries and bit patterns
		directed = '{32'd0, 32'd1, 32'd57, 32'd58, 32'd59, 32'd3363, 32'd3364,
			32'd195111, 32'd195112, 32'd11316495, 32'd11316496, 32'd656356767,
			32'd656356768, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000, 32'h7FFFFFFF,
			32'hAAAAAAAA, 32'h55555555, 32'd57 * 32'd58, 32'd1 << 16};
		foreach (directed[i])
			send_value(directed[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: begin
					tx_idle_pct  = 77;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 77;
				end
				3: begin
					tx_idle_pct  = 23;
					rx_stall_pct = 23;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_value(pick_value());
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		if (fail_count == 0 && chars_pending == 0)
			$display("base58_uid_encoder verification clean");
		else
			$display("base58_uid_encoder verification failed");
		$finish;
	end

endmodule
